>>> hdl/fcr_pkg.sv
// ----------------------------------------------------------------------------
// fcr_pkg
// shared types, sizes and codes of the framed command receiver
// ----------------------------------------------------------------------------
package fcr_pkg;

   localparam int ROBOT_COUNT  = 8;
   localparam int RECORD_BYTES = 16;
   localparam int HEADER_BYTES = 4;
   localparam int BODY_MAX     = ROBOT_COUNT * RECORD_BYTES + 1;

   localparam int ROBOT_W = (ROBOT_COUNT > 1) ? $clog2(ROBOT_COUNT) : 1;
   localparam int OFF_W   = $clog2(RECORD_BYTES);
   localparam int K_W     = $clog2(RECORD_BYTES + 1);
   localparam int TBL_AW  = $clog2(ROBOT_COUNT * RECORD_BYTES);
   localparam int BODY_AW = $clog2(BODY_MAX);
   localparam int BASE_W  = BODY_AW + 2;

   // operations
   localparam logic [1:0] OP_BYTE = 2'd0;
   localparam logic [1:0] OP_TICK = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;

   // frame status codes
   localparam logic [1:0] ST_NONE    = 2'd0;
   localparam logic [1:0] ST_COMMIT  = 2'd1;
   localparam logic [1:0] ST_FAIL    = 2'd2;
   localparam logic [1:0] ST_BAD_HDR = 2'd3;

   // register indexes
   localparam logic [1:0] REG_START_FIRST  = 2'd0;
   localparam logic [1:0] REG_START_SECOND = 2'd1;
   localparam logic [1:0] REG_STOP         = 2'd2;
   localparam logic [1:0] REG_DELAY        = 2'd3;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] rx_byte;
      logic [2:0] read_robot;
      logic [3:0] read_offset;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [1:0] frame_status;
   } rsp_type;

   typedef struct packed {
      logic               start;
      logic               clr_en;
      logic [ROBOT_W-1:0] clr_row;
   } timer_ctl_type;

   typedef struct packed {
      logic               busy;
      logic               done;
      logic               hit;
      logic [ROBOT_W-1:0] hit_row;
   } timer_sts_type;

   typedef struct packed {
      logic               wr_en;
      logic [ROBOT_W-1:0] wr_row;
      logic [OFF_W-1:0]   wr_off;
      logic [7:0]         wr_data;
      logic               rd_en;
      logic [2:0]         rd_robot;
      logic [3:0]         rd_offset;
      logic               fw_set;
      logic [ROBOT_W-1:0] fw_row;
      logic               fw_clr;
      logic [ROBOT_W-1:0] clr_row;
   } table_ctl_type;

endpackage

>>> hdl/fcr_timer.sv
// ----------------------------------------------------------------------------
// fcr_timer
// per-robot silence counters, aged one robot a cycle by a shared incrementer
// ----------------------------------------------------------------------------
module fcr_timer (
   input  logic                  clock,
   input  logic                  reset,
   input  fcr_pkg::timer_ctl_type ctl,
   input  logic [15:0]           delay,
   output fcr_pkg::timer_sts_type sts
);
   import fcr_pkg::*;

   logic [15:0]        cnt_ff [ROBOT_COUNT];
   logic               busy_ff, busy_in;
   logic [ROBOT_W-1:0] idx_ff, idx_in;
   logic [15:0]        next_cnt;
   logic               hit;
   logic               last;

   // shared increment and compare unit
   assign next_cnt = cnt_ff[idx_ff] + 16'd1;
   assign hit      = busy_ff && (next_cnt >= delay);
   assign last     = (32'(idx_ff) == ROBOT_COUNT - 1);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (busy_ff) begin
         if (last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + ROBOT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         for (int r = 0; r < ROBOT_COUNT; r++) begin
            cnt_ff[r] <= '0;
         end
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         if (busy_ff) begin
            cnt_ff[idx_ff] <= hit ? 16'd0 : next_cnt;
         end else if (ctl.clr_en) begin
            cnt_ff[ctl.clr_row] <= '0;
         end
      end
   end

   assign sts.busy    = busy_ff;
   assign sts.done    = busy_ff && last;
   assign sts.hit     = hit;
   assign sts.hit_row = idx_ff;

endmodule

>>> hdl/fcr_cmd_table.sv
// ----------------------------------------------------------------------------
// fcr_cmd_table
// command table memory with per-row freewheel flags and registered read
// ----------------------------------------------------------------------------
module fcr_cmd_table (
   input  logic                   clock,
   input  logic                   reset,
   input  fcr_pkg::table_ctl_type ctl,
   output logic [7:0]             rd_data
);
   import fcr_pkg::*;

   logic [7:0]             mem [ROBOT_COUNT * RECORD_BYTES];
   logic [ROBOT_COUNT-1:0] fw_ff, fw_in;
   logic [7:0]             mem_q_ff;
   logic                   hit_ff;
   logic                   sel_fw_ff;
   logic [7:0]             pat_ff;
   logic                   rd_hit;
   logic [ROBOT_W-1:0]     rd_row;
   logic [TBL_AW-1:0]      rd_addr;
   logic [TBL_AW-1:0]      wr_addr;
   logic [7:0]             pat;

   assign rd_hit  = (32'(ctl.rd_robot) < ROBOT_COUNT) && (32'(ctl.rd_offset) < RECORD_BYTES);
   assign rd_row  = ROBOT_W'(ctl.rd_robot);
   assign rd_addr = TBL_AW'(TBL_AW'(rd_row) * TBL_AW'(RECORD_BYTES) + TBL_AW'(ctl.rd_offset));
   assign wr_addr = TBL_AW'(TBL_AW'(ctl.wr_row) * TBL_AW'(RECORD_BYTES) + TBL_AW'(ctl.wr_off));

   // freewheel row: id, then 1..4, then zeros
   always_comb begin
      if (ctl.rd_offset == 4'd0) begin
         pat = 8'(ctl.rd_robot);
      end else if (ctl.rd_offset <= 4'd4) begin
         pat = 8'(ctl.rd_offset);
      end else begin
         pat = 8'd0;
      end
   end

   always_comb begin
      fw_in = fw_ff;
      if (ctl.fw_set) begin
         fw_in[ctl.fw_row] = 1'b1;
      end
      if (ctl.fw_clr) begin
         fw_in[ctl.clr_row] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff <= '1;
      end else begin
         fw_ff <= fw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= ctl.wr_data;
      end
      mem_q_ff <= mem[rd_addr];
      if (ctl.rd_en) begin
         hit_ff    <= rd_hit;
         sel_fw_ff <= fw_ff[rd_row];
         pat_ff    <= pat;
      end
   end

   assign rd_data = !hit_ff ? 8'd0 : (sel_fw_ff ? pat_ff : mem_q_ff);

endmodule

>>> hdl/framed_command_receiver_with_timeout_core.sv
// ----------------------------------------------------------------------------
// framed_command_receiver_with_timeout_core
// framed command receiver with checksum and per-robot silence timeout
// ----------------------------------------------------------------------------
// usage
//   req channel carries one request: a received byte, a timer tick or a
//   table read. rsp channel returns exactly one response per request with
//   read_data (table byte for a read, else 0) and frame_status.
//   csr port holds start bytes, stop byte and freewheel delay; write it only
//   while the block is idle.
// sequence (states from accept to response valid)
//   plain byte or unused op: FINISH only, table read: RD_WAIT then FINISH
//   tick: TICK while the single shared counter unit sweeps all robots, then FINISH
//   closing byte of a good frame: commit walk through the body memory,
//   CMT_ID and CMT_CHK per record, plus COPY per copied record, then FINISH
//   one request is in flight at a time; req_ready is low until the response
//   has been loaded into the output register
// reset
//   header collection restarts, all rows show the freewheel pattern, all
//   silence counters are zero, delay is 1000; no clearing pass is needed
// stalls
//   if rsp_ready is low the response waits in the output register and the
//   block holds the next response back until it has been taken
// ----------------------------------------------------------------------------
module framed_command_receiver_with_timeout_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  fcr_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output fcr_pkg::rsp_type rsp_payload,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [3:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import fcr_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_TICK    = 3'd1;
   localparam logic [2:0] S_CMT_ID  = 3'd2;
   localparam logic [2:0] S_CMT_CHK = 3'd3;
   localparam logic [2:0] S_COPY    = 3'd4;
   localparam logic [2:0] S_RD_WAIT = 3'd5;
   localparam logic [2:0] S_FINISH  = 3'd6;

   // configuration registers
   logic [7:0]  start0_ff, start1_ff, stop_ff;
   logic [15:0] delay_ff;
   logic        csr_wr;

   // sequencer and frame state
   logic [2:0]         state_ff, state_in;
   logic               phase_ff, phase_in;
   logic [7:0]         cnt_ff, cnt_in;
   logic [7:0]         hdr0_ff, hdr0_in, hdr1_ff, hdr1_in;
   logic [7:0]         len_ff, len_in;
   logic [7:0]         sum_ff, sum_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [ROBOT_W-1:0] id_ff, id_in;
   logic [1:0]         status_ff, status_in;
   logic [7:0]         data_ff, data_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // body memory
   logic [7:0]         body_mem [BODY_MAX];
   logic [7:0]         body_q_ff;
   logic               body_we;
   logic [BODY_AW-1:0] body_waddr;
   logic [BODY_AW-1:0] body_raddr;

   timer_ctl_type timer_ctl;
   timer_sts_type timer_sts;
   table_ctl_type table_ctl;
   logic [7:0]    table_rd;

   logic          accept;
   logic [7:0]    hdr_len;
   logic          hdr_bad;

   // ---------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         start0_ff <= '0;
         start1_ff <= '0;
         stop_ff   <= '0;
         delay_ff  <= 16'd1000;
      end else if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_START_FIRST:  start0_ff <= csr_pwdata[7:0];
            REG_START_SECOND: start1_ff <= csr_pwdata[7:0];
            REG_STOP:         stop_ff   <= csr_pwdata[7:0];
            REG_DELAY:        delay_ff  <= csr_pwdata[15:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_START_FIRST:  csr_prdata = {24'd0, start0_ff};
         REG_START_SECOND: csr_prdata = {24'd0, start1_ff};
         REG_STOP:         csr_prdata = {24'd0, stop_ff};
         REG_DELAY:        csr_prdata = {16'd0, delay_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // handshake
   // ---------------------------------------------------------------------
   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // body length and header check on the fourth header byte
   assign hdr_len = len_ff;
   assign hdr_bad = (hdr0_ff != start0_ff) || (hdr1_ff != start1_ff) || (hdr_len == 8'd0)
                    || (32'(hdr_len) > BODY_MAX);

   // body read address: record base plus byte within record
   assign body_raddr = BODY_AW'(base_ff + BASE_W'(k_ff));

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      hdr0_in      = hdr0_ff;
      hdr1_in      = hdr1_ff;
      len_in       = len_ff;
      sum_in       = sum_ff;
      base_in      = base_ff;
      k_in         = k_ff;
      id_in        = id_ff;
      status_in    = status_ff;
      data_in      = data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      body_we      = 1'b0;
      body_waddr   = BODY_AW'(cnt_ff);
      timer_ctl    = '0;
      table_ctl    = '0;

      table_ctl.rd_robot  = req_payload.read_robot;
      table_ctl.rd_offset = req_payload.read_offset;
      table_ctl.fw_set    = timer_sts.hit;
      table_ctl.fw_row    = timer_sts.hit_row;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               status_in = ST_NONE;
               data_in   = 8'd0;
               state_in  = S_FINISH;
               case (req_payload.operation)
                  OP_BYTE: begin
                     if (!phase_ff) begin
                        // header collection
                        case (cnt_ff[1:0])
                           2'd0: hdr0_in = req_payload.rx_byte;
                           2'd1: hdr1_in = req_payload.rx_byte;
                           2'd2: len_in  = req_payload.rx_byte - 8'(HEADER_BYTES);
                           default: ;
                        endcase
                        if (cnt_ff[1:0] == 2'd3) begin
                           cnt_in = 8'd0;
                           sum_in = req_payload.rx_byte;
                           if (hdr_bad) begin
                              status_in = ST_BAD_HDR;
                           end else begin
                              phase_in = 1'b1;
                           end
                        end else begin
                           cnt_in = cnt_ff + 8'd1;
                        end
                     end else begin
                        // body collection with running checksum
                        body_we = 1'b1;
                        if ({1'b0, cnt_ff} + 9'd1 < {1'b0, len_ff}) begin
                           sum_in = sum_ff - req_payload.rx_byte;
                           cnt_in = cnt_ff + 8'd1;
                        end else begin
                           phase_in = 1'b0;
                           cnt_in   = 8'd0;
                           if (req_payload.rx_byte == stop_ff && sum_ff == 8'd0) begin
                              base_in  = '0;
                              k_in     = '0;
                              state_in = S_CMT_ID;
                           end else begin
                              status_in = ST_FAIL;
                           end
                        end
                     end
                  end
                  OP_TICK: begin
                     timer_ctl.start = 1'b1;
                     state_in        = S_TICK;
                  end
                  OP_READ: begin
                     table_ctl.rd_en = 1'b1;
                     state_in        = S_RD_WAIT;
                  end
                  default: ;
               endcase
            end
         end
         S_TICK: begin
            if (timer_sts.done) begin
               state_in = S_FINISH;
            end
         end
         S_CMT_ID: begin
            // another whole record before the stop byte?
            if (base_ff + BASE_W'(RECORD_BYTES + 1) > BASE_W'(len_ff)) begin
               status_in = ST_COMMIT;
               state_in  = S_FINISH;
            end else begin
               state_in = S_CMT_CHK;
            end
         end
         S_CMT_CHK: begin
            if (32'(body_q_ff) < ROBOT_COUNT) begin
               id_in             = ROBOT_W'(body_q_ff);
               k_in              = '0;
               timer_ctl.clr_en  = 1'b1;
               timer_ctl.clr_row = ROBOT_W'(body_q_ff);
               table_ctl.fw_clr  = 1'b1;
               table_ctl.clr_row = ROBOT_W'(body_q_ff);
               state_in          = S_COPY;
            end else begin
               base_in  = base_ff + BASE_W'(RECORD_BYTES);
               state_in = S_CMT_ID;
            end
         end
         S_COPY: begin
            // read byte k, write byte k-1 from the registered read
            if (k_ff != '0) begin
               table_ctl.wr_en   = 1'b1;
               table_ctl.wr_row  = id_ff;
               table_ctl.wr_off  = OFF_W'(k_ff - K_W'(1));
               table_ctl.wr_data = body_q_ff;
            end
            if (32'(k_ff) == RECORD_BYTES) begin
               k_in     = '0;
               base_in  = base_ff + BASE_W'(RECORD_BYTES);
               state_in = S_CMT_ID;
            end else begin
               k_in = k_ff + K_W'(1);
            end
         end
         S_RD_WAIT: begin
            data_in  = table_rd;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_in.read_data    = data_ff;
               rsp_in.frame_status = status_ff;
               state_in            = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= 1'b0;
         cnt_ff       <= '0;
         hdr0_ff      <= '0;
         hdr1_ff      <= '0;
         len_ff       <= 8'd0 - 8'(HEADER_BYTES);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         hdr0_ff      <= hdr0_in;
         hdr1_ff      <= hdr1_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff    <= sum_in;
      base_ff   <= base_in;
      k_ff      <= k_in;
      id_ff     <= id_in;
      status_ff <= status_in;
      data_ff   <= data_in;
      rsp_ff    <= rsp_in;
   end

   // body memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (body_we) begin
         body_mem[body_waddr] <= req_payload.rx_byte;
      end
      body_q_ff <= body_mem[body_raddr];
   end

   fcr_timer u_timer (
      .clock (clock),
      .reset (reset),
      .ctl   (timer_ctl),
      .delay (delay_ff),
      .sts   (timer_sts)
   );

   fcr_cmd_table u_table (
      .clock   (clock),
      .reset   (reset),
      .ctl     (table_ctl),
      .rd_data (table_rd)
   );

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_timer_only_in_tick: assert property (@(posedge clock) disable iff (reset)
      timer_sts.busy |-> state_ff == S_TICK)
      else $error("silence timer sweeping outside a tick");

   a_table_write_in_copy: assert property (@(posedge clock) disable iff (reset)
      table_ctl.wr_en |-> state_ff == S_COPY)
      else $error("table written outside a commit copy");

   a_body_count_in_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff |-> cnt_ff < len_ff)
      else $error("body count reached frame length");

   a_commit_back_to_header: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CMT_ID || state_ff == S_CMT_CHK || state_ff == S_COPY) |-> !phase_ff)
      else $error("commit running while body collection is open");

endmodule
